// File: sv/binary_to_bcd_digit_driver_macros.svh
// Assertion macros used by binary_to_bcd_digit_driver.sv.
// ASSERT_IMPLIES checks the consequent in the same cycle.
// ASSERT_NEXT checks it in the following cycle.
`ifndef BINARY_TO_BCD_DIGIT_DRIVER_MACROS_SVH
`define BINARY_TO_BCD_DIGIT_DRIVER_MACROS_SVH

`ifndef SYNTHESIS
`define B2BCD_ASSERT_IMPLIES(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("b2bcd assertion failed");
`define B2BCD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("b2bcd assertion failed");
`else
`define B2BCD_ASSERT_IMPLIES(label, clock, reset, ante, cons)
`define B2BCD_ASSERT_NEXT(label, clock, reset, ante, cons)
`endif

`endif

// File: sv/b2bcd_pkg.sv
package b2bcd_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int COUNT_W    = 4;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int STEP_W     = $clog2(VALUE_W);
  localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(3);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               load;
    logic [VALUE_W-1:0] value;
  } dd_cmd_t;

  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } dd_rsp_t;

endpackage

// File: sv/b2bcd_dabble.sv
module b2bcd_dabble (
  input  logic               clk,
  input  logic               rst,
  input  b2bcd_pkg::dd_cmd_t cmd,
  output b2bcd_pkg::dd_rsp_t rsp
);
  import b2bcd_pkg::*;

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [STEP_W-1:0]  step;
  logic               running;
  logic               done;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[i*DIGIT_W +: DIGIT_W] = (bcd[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) ?
          bcd[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3) : bcd[i*DIGIT_W +: DIGIT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.load) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(VALUE_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // carry out of the top digit is dropped, leaving the value modulo 10^MAX_DIGITS
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= cmd.value;
      bcd <= '0;
    end else if (running) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.bcd  = bcd;

endmodule

// File: sv/binary_to_bcd_digit_driver.sv
// Binary to BCD digit driver.
// Pulse start with value while busy is low to hand over one 32-bit number.
// The block converts it by shift-and-add-3, one bit per cycle,
// then emits digit_count digits, most significant first, one per cycle.
// Each digit appears for one cycle with strobe high, together with
// bcd_digit, digit_select (0 is the most significant position) and last.
// busy stays high through the conversion and the digit emission, so a
// new start is taken only once the digits of the previous number are out.
// A digit_count above ten gives one result with error and last set, in the
// cycle after start, and no conversion. A digit_count of zero gives nothing.
// The configuration channel (cfg_valid, cfg_ready, cfg_data) writes
// digit_count; cfg_ready is low while busy. The receiver cannot stall:
// each result is taken in the cycle its strobe is high.
// Reset clears the sequencer and strobe and sets digit_count to 3.
`include "binary_to_bcd_digit_driver_macros.svh"

module binary_to_bcd_digit_driver (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [b2bcd_pkg::VALUE_W-1:0]   value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [b2bcd_pkg::COUNT_W-1:0]   cfg_data,
  output logic                            strobe,
  output logic [b2bcd_pkg::DIGIT_W-1:0]   bcd_digit,
  output logic [b2bcd_pkg::COUNT_W-1:0]   digit_select,
  output logic                            last,
  output logic                            error
);
  import b2bcd_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [COUNT_W-1:0]   digit_count;
  logic [COUNT_W-1:0]   k;
  logic [COUNT_W-1:0]   pos;
  logic                 last_digit;
  logic                 emit;
  logic                 err_emit;
  dd_cmd_t              dd_cmd;
  dd_rsp_t              dd_rsp;

  b2bcd_dabble u_dabble (
    .clk (clk),
    .rst (rst),
    .cmd (dd_cmd),
    .rsp (dd_rsp)
  );

  assign busy       = (state != ST_IDLE);
  assign cfg_ready  = !busy;
  assign pos        = digit_count - COUNT_W'(1) - k;
  assign last_digit = (k == digit_count - COUNT_W'(1));

  always_comb begin
    state_next   = state;
    dd_cmd.load  = 1'b0;
    dd_cmd.value = value;
    emit         = 1'b0;
    err_emit     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (digit_count > COUNT_W'(MAX_DIGITS)) begin
            err_emit = 1'b1;
          end else if (digit_count != '0) begin
            dd_cmd.load = 1'b1;
            state_next  = ST_CONVERT;
          end
        end
      end
      ST_CONVERT: begin
        if (dd_rsp.done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit = 1'b1;
        if (last_digit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      digit_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k      <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= emit || err_emit;
      if (dd_cmd.load) begin
        k <= '0;
      end else if (emit) begin
        k <= k + COUNT_W'(1);
      end
    end
  end

  // hold the result for its single strobe cycle
  always_ff @(posedge clk) begin
    if (err_emit) begin
      bcd_digit    <= '0;
      digit_select <= '0;
      last         <= 1'b1;
      error        <= 1'b1;
    end else if (emit) begin
      bcd_digit    <= dd_rsp.bcd[pos[IDX_W-1:0]*DIGIT_W +: DIGIT_W];
      digit_select <= k;
      last         <= last_digit;
      error        <= 1'b0;
    end
  end

  `B2BCD_ASSERT_IMPLIES(a_error_shape, clk, rst, strobe && error, last && bcd_digit == '0 && digit_select == '0)
  `B2BCD_ASSERT_NEXT(a_digits_contiguous, clk, rst, strobe && !last && !error, strobe && !error)
  `B2BCD_ASSERT_NEXT(a_no_early_digit, clk, rst, start && !busy, !strobe || error)
  `B2BCD_ASSERT_IMPLIES(a_select_range, clk, rst, strobe && !error, digit_select < COUNT_W'(MAX_DIGITS) && bcd_digit < DIGIT_W'(10))

endmodule

// File: tb/sv/binary_to_bcd_digit_driver_test.sv
module binary_to_bcd_digit_driver_test;
  import b2bcd_pkg::*;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic [COUNT_W-1:0] position;
    logic               last;
    logic               err;
  } bcd_result_t;

  // Listed rows carry their digits as hex nibbles, least significant digit
  // in the low nibble.
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] value;
    logic               listed;
    logic [BCD_W-1:0]   digits;
    logic               err;
  } bcd_case_t;

  localparam int NUM_CASES = 25;
  localparam int SETTLE_CYCLES = 50;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [VALUE_W-1:0]   value;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [COUNT_W-1:0]   cfg_data;
  logic                 strobe;
  logic [DIGIT_W-1:0]   bcd_digit;
  logic [COUNT_W-1:0]   digit_select;
  logic                 last;
  logic                 error;

  bcd_result_t          pending_digits[$];
  logic [COUNT_W-1:0]   digit_count_now;
  int                   mismatch_count = 0;

  bcd_case_t directed_cases [NUM_CASES] = '{
    '{4'd3,  32'd0,          1'b1, 40'h000,        1'b0},
    '{4'd3,  32'd123,        1'b1, 40'h123,        1'b0},
    '{4'd3,  32'hFFFFFFFF,   1'b1, 40'h295,        1'b0},
    '{4'd3,  32'd1000,       1'b1, 40'h000,        1'b0},
    '{4'd3,  32'd1,          1'b0, 40'h0,          1'b0},
    '{4'd10, 32'hFFFFFFFF,   1'b1, 40'h4294967295, 1'b0},
    '{4'd10, 32'd0,          1'b1, 40'h0,          1'b0},
    '{4'd10, 32'd1234567890, 1'b1, 40'h1234567890, 1'b0},
    '{4'd10, 32'hAAAAAAAA,   1'b0, 40'h0,          1'b0},
    '{4'd10, 32'h55555555,   1'b0, 40'h0,          1'b0},
    '{4'd1,  32'd9,          1'b1, 40'h9,          1'b0},
    '{4'd1,  32'hFFFFFFFF,   1'b1, 40'h5,          1'b0},
    '{4'd1,  32'h80000000,   1'b0, 40'h0,          1'b0},
    '{4'd0,  32'd55,         1'b1, 40'h0,          1'b0},
    '{4'd0,  32'hFFFFFFFF,   1'b1, 40'h0,          1'b0},
    '{4'd11, 32'd7,          1'b1, 40'h0,          1'b1},
    '{4'd12, 32'hFFFFFFFF,   1'b1, 40'h0,          1'b1},
    '{4'd13, 32'd0,          1'b1, 40'h0,          1'b1},
    '{4'd14, 32'h12345678,   1'b1, 40'h0,          1'b1},
    '{4'd15, 32'hFFFFFFFF,   1'b1, 40'h0,          1'b1},
    '{4'd15, 32'd0,          1'b1, 40'h0,          1'b1},
    '{4'd9,  32'd999999999,  1'b1, 40'h999999999,  1'b0},
    '{4'd7,  32'h0F0F0F0F,   1'b0, 40'h0,          1'b0},
    '{4'd4,  32'hF0F0F0F0,   1'b0, 40'h0,          1'b0},
    '{4'd2,  32'd99,         1'b1, 40'h99,         1'b0}
  };

  binary_to_bcd_digit_driver dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .value        (value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .strobe       (strobe),
    .bcd_digit    (bcd_digit),
    .digit_select (digit_select),
    .last         (last),
    .error        (error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected digits of v at the current count, most significant first, or an error.
  function automatic void queue_bcd_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] rest;
    logic [DIGIT_W-1:0] digs [MAX_DIGITS];
    int                 n;
    bcd_result_t        r;
    rest = v;
    n = int'(digit_count_now);
    if (n > MAX_DIGITS) begin
      r = '{digit: '0, position: '0, last: 1'b1, err: 1'b1};
      pending_digits.push_back(r);
    end else begin
      for (int k = n - 1; k >= 0; k--) begin
        digs[k] = DIGIT_W'(rest % 10);
        rest = rest / 10;
      end
      for (int k = 0; k < n; k++) begin
        r = '{digit: digs[k], position: COUNT_W'(k), last: (k == n - 1), err: 1'b0};
        pending_digits.push_back(r);
      end
    end
  endfunction

  function automatic void queue_listed_digits(input bcd_case_t c);
    bcd_result_t r;
    int          n;
    n = int'(c.count);
    if (c.err) begin
      r = '{digit: '0, position: '0, last: 1'b1, err: 1'b1};
      pending_digits.push_back(r);
    end else begin
      for (int k = 0; k < n; k++) begin
        r.digit    = c.digits[(n - 1 - k) * DIGIT_W +: DIGIT_W];
        r.position = COUNT_W'(k);
        r.last     = (k == n - 1);
        r.err      = 1'b0;
        pending_digits.push_back(r);
      end
    end
  endfunction

  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
      value <= $urandom;
    end
  endtask

  // Return at the edge that takes the transaction; start stays high.
  task automatic issue_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
  endtask

  task automatic write_digit_count(input logic [COUNT_W-1:0] n);
    // drop start so the last transaction is not taken again
    hold_off(1);
    while (pending_digits.size() != 0) @(posedge clk);
    // idle a while before the write
    hold_off(SETTLE_CYCLES + $urandom_range(0, 3));
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    digit_count_now = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_data  <= COUNT_W'($urandom);
  endtask

  always @(posedge clk) begin : check_digits
    bcd_result_t want;
    if (!rst && strobe) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected result: bcd_digit %0d digit_select %0d last %0b error %0b",
               bcd_digit, digit_select, last, error);
        mismatch_count++;
      end else begin
        want = pending_digits.pop_front();
        if (bcd_digit !== want.digit) begin
          $error("bcd_digit: expected %0d, got %0d", want.digit, bcd_digit);
          mismatch_count++;
        end
        if (digit_select !== want.position) begin
          $error("digit_select: expected %0d, got %0d", want.position, digit_select);
          mismatch_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last);
          mismatch_count++;
        end
        if (error !== want.err) begin
          $error("error: expected %0b, got %0b", want.err, error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : drive_values
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    logic [COUNT_W-1:0] n;
    bit                 steady;
    rst       = 1'b1;
    start     = 1'b0;
    value     = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    digit_count_now = COUNT_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_CASES; i++) begin
      if (directed_cases[i].count != digit_count_now)
        write_digit_count(directed_cases[i].count);
      if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 40));
      issue_value(directed_cases[i].value);
      if (directed_cases[i].listed) queue_listed_digits(directed_cases[i]);
      else queue_bcd_digits(directed_cases[i].value);
    end

    for (int phase = 0; phase < 18; phase++) begin
      case (phase)
        0: n = 4'd1;
        1: n = 4'd10;
        2: n = 4'd0;
        3: n = 4'd15;
        4: n = 4'd11;
        default: begin
          case ($urandom_range(0, 9))
            8: n = COUNT_W'($urandom_range(11, 15));
            9: n = COUNT_W'($urandom_range(0, 15));
            default: n = COUNT_W'($urandom_range(1, 10));
          endcase
        end
      endcase
      write_digit_count(n);
      // a stretch of back-to-back transactions
      steady = (phase == 6 || phase == 7);
      repeat (25) begin
        case ($urandom_range(0, 3))
          0: v = $urandom;
          1: v = $urandom_range(0, 999);
          2: begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = p - $urandom_range(0, 1);
          end
          default: v = $urandom_range(32'hFFFFFFFF - 1000, 32'hFFFFFFFF);
        endcase
        if (!steady && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 40));
        issue_value(v);
        queue_bcd_digits(v);
      end
    end

    hold_off(1);
    while (pending_digits.size() != 0) @(posedge clk);
    hold_off(SETTLE_CYCLES);
    if (mismatch_count == 0)
      $display("binary_to_bcd_digit_driver regression: pass");
    else
      $display("binary_to_bcd_digit_driver regression: fail");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("binary_to_bcd_digit_driver regression: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/b2bcd_pkg.sv
sv/b2bcd_dabble.sv
sv/binary_to_bcd_digit_driver.sv
tb/sv/binary_to_bcd_digit_driver_test.sv
